// ===== design/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg: shared definitions for the text console cursor
// Screen geometry, character codes and the draw command record.
// ----------------------------------------------------------------------------
package tcc_pkg;

   // screen geometry in character cells
   localparam int unsigned COLUMNS = 76;
   localparam int unsigned ROWS    = 26;

   // cursor and payload widths
   localparam int unsigned COL_W    = 7;
   localparam int unsigned ROW_W    = 5;
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned X_W      = 10;
   localparam int unsigned Y_W      = 8;
   localparam int unsigned COLOUR_W = 32;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_END     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TILDE   = 8'h7E;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_C = 8'h63;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_C = 8'h43;

   // ascii zero, subtracted from each colour digit
   localparam logic [COLOUR_W-1:0] DIGIT_BASE = 32'h0000_0030;

   // pixel offset of cell zero
   localparam logic [X_W-1:0] X_OFFSET = 10'd16;
   localparam logic [Y_W-1:0] Y_OFFSET = 8'd16;

   // colour digit field positions
   localparam int unsigned SHIFT_D1 = 5;
   localparam int unsigned SHIFT_D2 = 13;
   localparam int unsigned SHIFT_D3 = 21;

   // one glyph draw command
   typedef struct packed {
      logic [X_W-1:0]      x_pixel;
      logic [Y_W-1:0]      y_pixel;
      logic [CHAR_W-1:0]   glyph;
      logic [COLOUR_W-1:0] colour;
   } draw_type;

endpackage

// ===== design/text_console_cursor.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor: character stream front end of a text overlay
// Tracks the cursor and colour escapes and issues one glyph draw command
// for each printable character while the screen has room.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_stall, req_character     | in
//  rsp     | rsp_valid, rsp_stall, rsp_x_pixel,      | out
//          | rsp_y_pixel, rsp_glyph, rsp_colour      |
//
// One character per cycle while req_stall is low. A character is decoded
// against the cursor and escape registers in the cycle it transfers; a draw
// command is registered in the result or skid register and leaves on rsp.
// A skid register behind the result register keeps req open while one result
// waits; req_stall comes straight from the skid register's valid bit.
// Reset clears cursor, colour, escape phase and both result valid bits.
//
module text_console_cursor
   import tcc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CHAR_W-1:0]   req_character,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [X_W-1:0]      rsp_x_pixel,
   output logic [Y_W-1:0]      rsp_y_pixel,
   output logic [CHAR_W-1:0]   rsp_glyph,
   output logic [COLOUR_W-1:0] rsp_colour
);

   typedef enum logic [2:0] {
      PH_NORMAL,
      PH_TILDE,
      PH_D1,
      PH_D2,
      PH_D3
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COLOUR_W-1:0] colour_ff, colour_in;
   logic [CHAR_W-1:0]   first_digit_ff, first_digit_in;
   logic [CHAR_W-1:0]   second_digit_ff, second_digit_in;

   logic                out_valid_ff, out_valid_in;
   draw_type            out_ff, out_in;
   logic                skid_valid_ff, skid_valid_in;
   draw_type            skid_ff, skid_in;

   logic                accept;
   logic                take;
   logic                draw_valid;
   draw_type            draw;
   logic [COL_W:0]      col_plus;
   logic                col_wrap;
   logic [ROW_W-1:0]    row_plus;
   logic [COLOUR_W-1:0] field_d1;
   logic [COLOUR_W-1:0] field_d2;
   logic [COLOUR_W-1:0] field_d3;

   // handshakes
   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   // cursor advance
   assign col_plus = {1'b0, col_ff} + {{COL_W{1'b0}}, 1'b1};
   assign col_wrap = (32'(col_plus) >= COLUMNS);
   assign row_plus = row_ff + {{(ROW_W-1){1'b0}}, 1'b1};

   // colour digit fields, two's complement wrap
   assign field_d1 = ({{(COLOUR_W-CHAR_W){1'b0}}, first_digit_ff} - DIGIT_BASE) << SHIFT_D1;
   assign field_d2 = ({{(COLOUR_W-CHAR_W){1'b0}}, second_digit_ff} - DIGIT_BASE) << SHIFT_D2;
   assign field_d3 = ({{(COLOUR_W-CHAR_W){1'b0}}, req_character} - DIGIT_BASE) << SHIFT_D3;

   // draw command for the current cursor
   always_comb begin
      draw.x_pixel = {col_ff, 3'b000} + X_OFFSET;
      draw.y_pixel = {row_ff, 3'b000} + Y_OFFSET;
      draw.glyph   = req_character;
      draw.colour  = colour_ff;
   end

   // character decode and escape sequencing
   always_comb begin
      phase_in        = phase_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      colour_in       = colour_ff;
      first_digit_in  = first_digit_ff;
      second_digit_in = second_digit_ff;
      draw_valid      = 1'b0;
      if (accept) begin
         if (req_character == CHAR_END) begin
            phase_in = PH_NORMAL;
         end else begin
            unique case (phase_ff)
               PH_TILDE: begin
                  phase_in = (req_character == CHAR_LOWER_C ||
                              req_character == CHAR_UPPER_C) ? PH_D1 : PH_NORMAL;
               end
               PH_D1: begin
                  first_digit_in = req_character;
                  phase_in       = PH_D2;
               end
               PH_D2: begin
                  second_digit_in = req_character;
                  phase_in        = PH_D3;
               end
               PH_D3: begin
                  colour_in = field_d1 | field_d2 | field_d3;
                  phase_in  = PH_NORMAL;
               end
               default: begin
                  phase_in = PH_NORMAL;
                  if (32'(row_ff) < ROWS) begin
                     if (req_character == CHAR_NEWLINE) begin
                        col_in = '0;
                        row_in = row_plus;
                     end else if (req_character == CHAR_TILDE) begin
                        phase_in = PH_TILDE;
                     end else begin
                        // printable draws, then space and printable advance
                        draw_valid = (req_character != CHAR_SPACE);
                        if (col_wrap) begin
                           col_in = '0;
                           row_in = row_plus;
                        end else begin
                           col_in = col_plus[COL_W-1:0];
                        end
                     end
                  end
               end
            endcase
         end
      end
   end

   // result register and skid register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (draw_valid) begin
         if (!out_valid_ff || take) begin
            out_in       = draw;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = draw;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      first_digit_ff  <= first_digit_in;
      second_digit_ff <= second_digit_in;
      out_ff          <= out_in;
      skid_ff         <= skid_in;
      if (reset) begin
         phase_ff      <= PH_NORMAL;
         col_ff        <= '0;
         row_ff        <= '0;
         colour_ff     <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         colour_ff     <= colour_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result transfer
   assign rsp_valid   = out_valid_ff;
   assign rsp_x_pixel = out_ff.x_pixel;
   assign rsp_y_pixel = out_ff.y_pixel;
   assign rsp_glyph   = out_ff.glyph;
   assign rsp_colour  = out_ff.colour;

endmodule

// ===== sim/text_console_cursor_test.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_test: self-checking bench for the text console cursor
// Streams characters into the block, including opening edge cases, colour
// escapes and random strings, with random idle and stall cycles on both
// sides. Every draw command is checked against a cycle-free predictor of the
// cursor, the colour word and the escape parser.
// ----------------------------------------------------------------------------
module text_console_cursor_test
   import tcc_pkg::*;
;

   // escape parser phase
   typedef enum logic [2:0] {
      PHASE_NORMAL,
      PHASE_TILDE,
      PHASE_D1,
      PHASE_D2,
      PHASE_D3
   } escape_phase_type;

   // predicts draw commands and checks them in order
   class cursor_scoreboard;
      draw_type            pending_draws[$];
      logic [COL_W-1:0]    column;
      logic [ROW_W-1:0]    row;
      logic [COLOUR_W-1:0] colour;
      logic [CHAR_W-1:0]   first_digit;
      logic [CHAR_W-1:0]   second_digit;
      escape_phase_type    phase;
      int                  mismatches;
      int                  draws_seen;

      function new();
         column       = '0;
         row          = '0;
         colour       = '0;
         first_digit  = '0;
         second_digit = '0;
         phase        = PHASE_NORMAL;
         mismatches   = 0;
         draws_seen   = 0;
      endfunction

      // cells still free before the screen is full
      function int cells_left();
         return (int'(ROWS) - int'(row)) * int'(COLUMNS) - int'(column);
      endfunction

      // one colour field: digit zero extended, minus ascii zero, then shifted
      function logic [COLOUR_W-1:0] digit_field(logic [CHAR_W-1:0] d, int shift);
         return (COLOUR_W'(d) - DIGIT_BASE) << shift;
      endfunction

      function void step_column();
         if (int'(column) + 1 >= int'(COLUMNS)) begin
            column = '0;
            row    = row + 1'b1;
         end else begin
            column = column + 1'b1;
         end
      endfunction

      // accepted character: update the cursor state and queue any draw
      function void note_character(logic [CHAR_W-1:0] c);
         draw_type want;
         if (c == CHAR_END) begin
            phase = PHASE_NORMAL;
            return;
         end
         case (phase)
            PHASE_TILDE: begin
               phase = (c == CHAR_LOWER_C || c == CHAR_UPPER_C) ? PHASE_D1 : PHASE_NORMAL;
               return;
            end
            PHASE_D1: begin
               first_digit = c;
               phase       = PHASE_D2;
               return;
            end
            PHASE_D2: begin
               second_digit = c;
               phase        = PHASE_D3;
               return;
            end
            PHASE_D3: begin
               colour = digit_field(first_digit, SHIFT_D1) |
                        digit_field(second_digit, SHIFT_D2) |
                        digit_field(c, SHIFT_D3);
               phase  = PHASE_NORMAL;
               return;
            end
            default: phase = PHASE_NORMAL;
         endcase
         // screen full: everything is dropped
         if (int'(row) >= int'(ROWS)) return;
         if (c == CHAR_SPACE) begin
            step_column();
         end else if (c == CHAR_NEWLINE) begin
            column = '0;
            row    = row + 1'b1;
         end else if (c == CHAR_TILDE) begin
            phase = PHASE_TILDE;
         end else begin
            want.x_pixel = (X_W'(column) << 3) + X_OFFSET;
            want.y_pixel = (Y_W'(row) << 3) + Y_OFFSET;
            want.glyph   = c;
            want.colour  = colour;
            pending_draws.push_back(want);
            step_column();
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      // accepted draw command against the oldest prediction
      task check_draw(draw_type got);
         draw_type want;
         draws_seen++;
         if (pending_draws.size() == 0) begin
            report_mismatch($sformatf("draw %0d not predicted, glyph %h at (%0d,%0d)",
                                      draws_seen, got.glyph, got.x_pixel, got.y_pixel));
            return;
         end
         want = pending_draws.pop_front();
         if (got.x_pixel !== want.x_pixel)
            report_mismatch($sformatf("draw %0d x_pixel %0d, want %0d",
                                      draws_seen, got.x_pixel, want.x_pixel));
         if (got.y_pixel !== want.y_pixel)
            report_mismatch($sformatf("draw %0d y_pixel %0d, want %0d",
                                      draws_seen, got.y_pixel, want.y_pixel));
         if (got.glyph !== want.glyph)
            report_mismatch($sformatf("draw %0d glyph %h, want %h",
                                      draws_seen, got.glyph, want.glyph));
         if (got.colour !== want.colour)
            report_mismatch($sformatf("draw %0d colour %h, want %h",
                                      draws_seen, got.colour, want.colour));
      endtask
   endclass

   localparam int ITEM_TARGET  = 1950;
   localparam int QUIET_LIMIT  = 400;
   localparam int DRAIN_CYCLES = 20;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [CHAR_W-1:0]   req_character = '0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [X_W-1:0]      rsp_x_pixel;
   logic [Y_W-1:0]      rsp_y_pixel;
   logic [CHAR_W-1:0]   rsp_glyph;
   logic [COLOUR_W-1:0] rsp_colour;

   cursor_scoreboard board = new();

   int sent_count   = 0;
   int send_gap_max = 0;
   int stall_max    = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;

   // opening strings: field extremes, plain text, both colour escapes,
   // swallowed escapes and an escape cut short by end of string
   logic [CHAR_W-1:0] opening_text[$] = '{
      8'h41, 8'hFF, 8'h01, CHAR_SPACE, 8'h7A, CHAR_NEWLINE,
      CHAR_TILDE, CHAR_LOWER_C, 8'h31, 8'h32, 8'h33, 8'h71,
      CHAR_TILDE, CHAR_UPPER_C, 8'hFF, 8'h01, 8'h30, 8'h77,
      CHAR_TILDE, 8'h78, CHAR_TILDE, CHAR_TILDE, 8'h21,
      CHAR_TILDE, CHAR_LOWER_C, 8'h39, CHAR_END, 8'h42
   };

   text_console_cursor uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_character (req_character),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_x_pixel   (rsp_x_pixel),
      .rsp_y_pixel   (rsp_y_pixel),
      .rsp_glyph     (rsp_glyph),
      .rsp_colour    (rsp_colour)
   );

   always #5 clock = ~clock;

   function automatic int pick_idle_limit();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 4;
         default: return 18;
      endcase
   endfunction

   // printable byte that is not a control code of the block
   function automatic logic [CHAR_W-1:0] random_glyph();
      logic [CHAR_W-1:0] c;
      do
         c = CHAR_W'($urandom_range(1, 255));
      while (c == CHAR_NEWLINE || c == CHAR_SPACE || c == CHAR_TILDE);
      return c;
   endfunction

   // mostly decimal digits, sometimes any nonzero byte
   function automatic logic [CHAR_W-1:0] random_digit();
      if ($urandom_range(0, 9) < 7)
         return DIGIT_BASE[CHAR_W-1:0] + CHAR_W'($urandom_range(0, 9));
      return CHAR_W'($urandom_range(1, 255));
   endfunction

   // one req transfer after a random idle gap
   task automatic send_character(input logic [CHAR_W-1:0] c);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_character(c);
      sent_count++;
      if (sent_count % 40 == 0) send_gap_max = pick_idle_limit();
   endtask

   // one random piece of a string, always leaving the parser in normal phase
   task automatic send_segment();
      int pick;
      int room;
      int count;
      logic [CHAR_W-1:0] other;
      room = board.cells_left() - (ITEM_TARGET - sent_count) * 3 / 4;
      pick = (board.cells_left() <= 40) ? $urandom_range(65, 99) : $urandom_range(0, 99);
      if (pick < 45) begin
         count = $urandom_range(1, 8);
         repeat (count) send_character(random_glyph());
      end else if (pick < 60) begin
         count = $urandom_range(1, 6);
         repeat (count) send_character(CHAR_SPACE);
      end else if (pick < 65) begin
         if (room > int'(COLUMNS) + 40)
            send_character(CHAR_NEWLINE);
         else
            send_character(random_glyph());
      end else if (pick < 80) begin
         // colour escape
         send_character(CHAR_TILDE);
         send_character($urandom_range(0, 1) ? CHAR_LOWER_C : CHAR_UPPER_C);
         repeat (3) send_character(random_digit());
      end else if (pick < 87) begin
         // swallowed escape
         do
            other = CHAR_W'($urandom_range(1, 255));
         while (other == CHAR_LOWER_C || other == CHAR_UPPER_C);
         send_character(CHAR_TILDE);
         send_character(other);
      end else if (pick < 93) begin
         send_character(CHAR_END);
      end else begin
         // escape cut short by end of string
         send_character(CHAR_TILDE);
         if ($urandom_range(0, 1)) begin
            send_character($urandom_range(0, 1) ? CHAR_LOWER_C : CHAR_UPPER_C);
            count = $urandom_range(0, 2);
            repeat (count) send_character(random_digit());
         end
         send_character(CHAR_END);
      end
   endtask

   // rsp side: check each transfer, then stall the next result a random while
   always @(posedge clock) begin
      draw_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.x_pixel = rsp_x_pixel;
            got.y_pixel = rsp_y_pixel;
            got.glyph   = rsp_glyph;
            got.colour  = rsp_colour;
            board.check_draw(got);
            if (board.draws_seen % 40 == 0) stall_max = pick_idle_limit();
            stall_left = $urandom_range(0, stall_max);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            if (rsp_valid) stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("FAIL text_console_cursor");
      $finish;
   end

   // stimulus and end of run
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_text[i]) send_character(opening_text[i]);

      while (sent_count < ITEM_TARGET) send_segment();

      // fill the screen: newlines down to the last row, then wrap off it
      while (int'(board.row) < int'(ROWS) - 1) send_character(CHAR_NEWLINE);
      while (int'(board.row) < int'(ROWS)) send_character(random_glyph());

      // screen full: all of this must be dropped, across string ends too
      repeat (40) send_character(CHAR_W'($urandom_range(0, 255)));
      send_character(CHAR_TILDE);
      send_character(CHAR_LOWER_C);
      send_character(CHAR_NEWLINE);

      req_valid <= 1'b0;
      while (board.pending_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0)
         $display("PASS text_console_cursor");
      else
         $display("FAIL text_console_cursor");
      $finish;
   end

endmodule
